// ----- rtl/core/psa_pkg.sv -----
// Shared types and constants of the paged slab allocator.
package psa_pkg;

    // Sizes of the managed range and of the element chains.
    localparam int PAGES     = 256;
    localparam int MAX_ELEMS = 256;

    // Page index width, and width of a page index that can also hold nil.
    localparam int PAW = $clog2(PAGES);
    localparam int PNW = $clog2(PAGES + 1);
    // Element index width, and width of a count or chain link that can hold nil.
    localparam int EAW = $clog2(MAX_ELEMS);
    localparam int CW  = $clog2(MAX_ELEMS + 1);
    // Element size and byte offset widths.
    localparam int ESW = 17;
    localparam int OFW = 24;

    localparam logic [PNW-1:0] NIL_P = PNW'(PAGES);
    localparam logic [CW-1:0]  NIL_E = CW'(MAX_ELEMS);

    // Per-page bookkeeping record, kept in one memory.
    typedef struct packed {
        logic [CW-1:0]  chain;
        logic [CW-1:0]  bump;
        logic [CW-1:0]  used;
        logic [CW-1:0]  total;
        logic [ESW-1:0] esize;
    } rec_t;

    // Commands of the page list unit.
    typedef enum logic [1:0] {
        LC_IN            = 2'd0,
        LC_OUT           = 2'd1,
        LC_OUT_IF_LINKED = 2'd2
    } list_cmd_e;

    typedef struct packed {
        logic            valid;
        list_cmd_e       cmd;
        logic [PAW-1:0]  page;
        logic [PNW-1:0]  head;
    } list_req_t;

    typedef struct packed {
        logic            done;
        logic [PNW-1:0]  head;
    } list_rsp_t;

endpackage

// ----- rtl/core/psa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module psa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/psa_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
module psa_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [psa_pkg::OFW-1:0] dividend,
    input  logic [psa_pkg::ESW-1:0] divisor,
    output logic                   done,
    output logic [psa_pkg::OFW-1:0] quo,
    output logic [psa_pkg::ESW-1:0] rem
);
    import psa_pkg::*;

    localparam int CNTW = $clog2(OFW);

    logic            run_reg, run_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [OFW-1:0]  quo_reg, quo_next;
    logic [ESW-1:0]  rem_reg, rem_next;
    logic [ESW-1:0]  dvs_reg, dvs_next;
    logic [ESW:0]    rem_sh;
    logic [ESW:0]    diff;
    logic            ge;

    // One shift-and-subtract step on the partial remainder.
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[OFW-1]};
        diff   = rem_sh - {1'b0, dvs_reg};
        ge     = (rem_sh >= {1'b0, dvs_reg});
    end

    // Step sequencing.
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            quo_next = {quo_reg[OFW-2:0], ge};
            rem_next = ge ? diff[ESW-1:0] : rem_sh[ESW-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNTW'(OFW - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

// ----- rtl/core/psa_list.sv -----
// Page list unit: links pages into and out of circular doubly linked lists.
module psa_list (
    input  logic               clk,
    input  logic               rst_n,
    input  psa_pkg::list_req_t req,
    output psa_pkg::list_rsp_t rsp
);
    import psa_pkg::*;

    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_RD   = 3'b010,
        L_W2   = 3'b100
    } lstate_t;

    lstate_t        state_reg, state_next;
    list_cmd_e      cmd_reg, cmd_next;
    logic [PAW-1:0] page_reg, page_next;
    logic [PNW-1:0] head_reg, head_next;
    logic [PNW-1:0] link_reg, link_next;
    logic           done_reg, done_next;
    logic [PNW-1:0] rhead_reg, rhead_next;

    logic           nl_we, pl_we;
    logic [PAW-1:0] nl_waddr, pl_waddr, nl_raddr, pl_raddr;
    logic [PNW-1:0] nl_wdata, pl_wdata, nl_rdata, pl_rdata;

    // Next and previous link memories.
    psa_ram #(.WIDTH(PNW), .DEPTH(PAGES)) u_next_ram (
        .clk(clk), .we(nl_we), .waddr(nl_waddr), .wdata(nl_wdata),
        .raddr(nl_raddr), .rdata(nl_rdata)
    );

    psa_ram #(.WIDTH(PNW), .DEPTH(PAGES)) u_prev_ram (
        .clk(clk), .we(pl_we), .waddr(pl_waddr), .wdata(pl_wdata),
        .raddr(pl_raddr), .rdata(pl_rdata)
    );

    // Link sequencer: reads links for L_RD, then writes in L_RD and L_W2 as needed.
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        page_next  = page_reg;
        head_next  = head_reg;
        link_next  = link_reg;
        done_next  = 1'b0;
        rhead_next = rhead_reg;
        nl_we      = 1'b0;
        pl_we      = 1'b0;
        nl_waddr   = page_reg;
        pl_waddr   = page_reg;
        nl_wdata   = NIL_P;
        pl_wdata   = NIL_P;
        nl_raddr   = page_reg;
        pl_raddr   = page_reg;
        unique case (state_reg)
            L_IDLE:
            begin
                nl_raddr = (req.cmd == LC_IN) ? req.head[PAW-1:0] : req.page;
                pl_raddr = req.page;
                if (req.valid)
                begin
                    cmd_next  = req.cmd;
                    page_next = req.page;
                    head_next = req.head;
                    if (req.cmd == LC_IN && req.head == NIL_P)
                    begin
                        // Empty list: the page links to itself and becomes the head.
                        nl_we      = 1'b1;
                        pl_we      = 1'b1;
                        nl_waddr   = req.page;
                        pl_waddr   = req.page;
                        nl_wdata   = {1'b0, req.page};
                        pl_wdata   = {1'b0, req.page};
                        done_next  = 1'b1;
                        rhead_next = {1'b0, req.page};
                    end
                    else
                    begin
                        state_next = L_RD;
                    end
                end
            end
            L_RD:
            begin
                if (cmd_reg == LC_IN)
                begin
                    // Insert after the head: set the new page's own links first.
                    pl_we      = 1'b1;
                    pl_wdata   = head_reg;
                    nl_we      = 1'b1;
                    nl_wdata   = nl_rdata;
                    link_next  = nl_rdata;
                    state_next = L_W2;
                end
                else if (cmd_reg == LC_OUT_IF_LINKED && nl_rdata == NIL_P)
                begin
                    done_next  = 1'b1;
                    rhead_next = head_reg;
                    state_next = L_IDLE;
                end
                else
                begin
                    // Bridge the neighbors around the page.
                    nl_we      = 1'b1;
                    nl_waddr   = pl_rdata[PAW-1:0];
                    nl_wdata   = nl_rdata;
                    pl_we      = 1'b1;
                    pl_waddr   = nl_rdata[PAW-1:0];
                    pl_wdata   = pl_rdata;
                    link_next  = nl_rdata;
                    state_next = L_W2;
                end
            end
            L_W2:
            begin
                done_next  = 1'b1;
                state_next = L_IDLE;
                nl_we      = 1'b1;
                pl_we      = 1'b1;
                if (cmd_reg == LC_IN)
                begin
                    nl_waddr   = head_reg[PAW-1:0];
                    nl_wdata   = {1'b0, page_reg};
                    pl_waddr   = link_reg[PAW-1:0];
                    pl_wdata   = {1'b0, page_reg};
                    rhead_next = head_reg;
                end
                else
                begin
                    // Clear the removed page's links and move the head on if needed.
                    if (head_reg == {1'b0, page_reg})
                    begin
                        rhead_next = (link_reg == {1'b0, page_reg}) ? NIL_P : link_reg;
                    end
                    else
                    begin
                        rhead_next = head_reg;
                    end
                end
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        page_reg  <= page_next;
        head_reg  <= head_next;
        link_reg  <= link_next;
        rhead_reg <= rhead_next;
    end

    assign rsp.done = done_reg;
    assign rsp.head = rhead_reg;

endmodule

// ----- rtl/core/paged_slab_allocator_core.sv -----
// Top level of the paged slab allocator: sequencer, page records and element chains.
//
// Channel   Direction  Handshake                      Payload
// request   in         start & !busy                  opcode, list_head, list_head_valid,
//                                                     elem_bytes, free_offset
// result    out        done, one cycle                status, alloc_offset, new_head,
//                                                     new_head_valid, commit_page,
//                                                     decommit_page, touched_page
// config    in/out     psel & penable & pwrite        paddr, pwdata, prdata, pready
//
// One item at a time. An allocate from a non-empty list runs no division;
// one that opens a new page adds a 24-step division.
// A free runs one or two 24-step divisions in the shared divider.
// Reset clears the sequencer and the cache, virtual and fresh page state at once.
// The result is shown for one cycle with done; the receiver cannot stall it.
module paged_slab_allocator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic        opcode,
    input  logic [7:0]  list_head,
    input  logic        list_head_valid,
    input  logic [16:0] elem_bytes,
    input  logic [23:0] free_offset,
    output logic        status,
    output logic [23:0] alloc_offset,
    output logic [7:0]  new_head,
    output logic        new_head_valid,
    output logic        commit_page,
    output logic        decommit_page,
    output logic [7:0]  touched_page,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import psa_pkg::*;

    localparam logic [1:0] REG_PAGE_SIZE   = 2'd0;
    localparam logic [1:0] REG_PAGE_COUNT  = 2'd1;
    localparam logic [1:0] REG_CACHE_LIMIT = 2'd2;
    localparam logic       OP_ALLOC        = 1'b0;
    localparam logic       OP_FREE         = 1'b1;

    typedef enum logic [19:0] {
        S_IDLE    = 20'h00001,
        S_START   = 20'h00002,
        S_A_TAKEW = 20'h00004,
        S_A_DIV   = 20'h00008,
        S_A_DIVW  = 20'h00010,
        S_A_LINKW = 20'h00020,
        S_A_HEAD  = 20'h00040,
        S_A_PICK  = 20'h00080,
        S_A_CHAIN = 20'h00100,
        S_A_USE   = 20'h00200,
        S_A_OUTW  = 20'h00400,
        S_A_MUL1  = 20'h00800,
        S_A_MUL2  = 20'h01000,
        S_F_DIVW1 = 20'h02000,
        S_F_REC   = 20'h04000,
        S_F_DIVW2 = 20'h08000,
        S_F_OUTW  = 20'h10000,
        S_F_INW   = 20'h20000,
        S_F_PUTW  = 20'h40000,
        S_DONE    = 20'h80000
    } state_t;

    // Configuration registers.
    logic [16:0] page_size_reg;
    logic [8:0]  page_count_reg;
    logic [8:0]  cache_limit_reg;
    logic        cfg_wr;

    // Global allocator state.
    state_t         state_reg, state_next;
    logic [PNW-1:0] fresh_reg, fresh_next;
    logic [PNW-1:0] cache_head_reg, cache_head_next;
    logic [PNW-1:0] cache_count_reg, cache_count_next;
    logic [PNW-1:0] virt_head_reg, virt_head_next;

    // Captured item and working values.
    logic           op_reg, op_next;
    logic [7:0]     lh_reg, lh_next;
    logic           lhv_reg, lhv_next;
    logic [ESW-1:0] esz_reg, esz_next;
    logic [OFW-1:0] off_reg, off_next;
    logic [PNW-1:0] head_reg, head_next;
    logic [PAW-1:0] p_reg, p_next;
    logic [CW-1:0]  e_reg, e_next;
    logic [ESW-1:0] rem_reg, rem_next;
    rec_t           rec_reg, rec_next;
    logic           take_cache_reg, take_cache_next;

    // Result fields.
    logic           status_reg, status_next;
    logic [OFW-1:0] offset_reg, offset_next;
    logic           commit_reg, commit_next;
    logic           decommit_reg, decommit_next;
    logic [PAW-1:0] touched_reg, touched_next;
    logic           echo_reg, echo_next;

    // Derived configuration values.
    logic [ESW-1:0] ps;
    logic [PNW-1:0] cnt;

    // Shared divider, multiplier, list unit and memories.
    logic           div_start, div_done;
    logic [OFW-1:0] div_a, div_q;
    logic [ESW-1:0] div_b, div_r;
    logic [CW-1:0]  mul_a;
    logic [ESW-1:0] mul_b;
    logic [CW+ESW-1:0] mul_p;
    list_req_t      lreq;
    list_rsp_t      lrsp;
    logic           rec_we;
    logic [PAW-1:0] rec_raddr;
    rec_t           rec_wdata, rec_rdata;
    logic           el_we;
    logic [PAW+EAW-1:0] el_waddr, el_raddr;
    logic [CW-1:0]  el_wdata, el_rdata;
    logic [CW-1:0]  used_inc, used_dec;

    psa_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
        .divisor(div_b), .done(div_done), .quo(div_q), .rem(div_r)
    );

    psa_list u_list (
        .clk(clk), .rst_n(rst_n), .req(lreq), .rsp(lrsp)
    );

    psa_ram #(.WIDTH($bits(rec_t)), .DEPTH(PAGES)) u_rec_ram (
        .clk(clk), .we(rec_we), .waddr(p_reg), .wdata(rec_wdata),
        .raddr(rec_raddr), .rdata(rec_rdata)
    );

    psa_ram #(.WIDTH(CW), .DEPTH(PAGES * (2 ** EAW))) u_link_ram (
        .clk(clk), .we(el_we), .waddr(el_waddr), .wdata(el_wdata),
        .raddr(el_raddr), .rdata(el_rdata)
    );

    // A page size of zero counts as one; the page count is clipped to the range.
    assign ps  = (page_size_reg == '0) ? ESW'(1) : page_size_reg;
    assign cnt = (page_count_reg > 9'(PAGES)) ? PNW'(PAGES) : PNW'(page_count_reg);

    assign mul_p    = mul_a * mul_b;
    assign used_inc = rec_reg.used + 1'b1;
    assign used_dec = rec_reg.used - 1'b1;

    // Main sequencer.
    always_comb
    begin
        state_next       = state_reg;
        fresh_next       = fresh_reg;
        cache_head_next  = cache_head_reg;
        cache_count_next = cache_count_reg;
        virt_head_next   = virt_head_reg;
        op_next          = op_reg;
        lh_next          = lh_reg;
        lhv_next         = lhv_reg;
        esz_next         = esz_reg;
        off_next         = off_reg;
        head_next        = head_reg;
        p_next           = p_reg;
        e_next           = e_reg;
        rem_next         = rem_reg;
        rec_next         = rec_reg;
        take_cache_next  = take_cache_reg;
        status_next      = status_reg;
        offset_next      = offset_reg;
        commit_next      = commit_reg;
        decommit_next    = decommit_reg;
        touched_next     = touched_reg;
        echo_next        = echo_reg;
        div_start        = 1'b0;
        div_a            = off_reg;
        div_b            = ps;
        mul_a            = {1'b0, p_reg};
        mul_b            = ps;
        lreq             = '0;
        lreq.cmd         = LC_IN;
        lreq.page        = p_reg;
        lreq.head        = head_reg;
        rec_we           = 1'b0;
        rec_wdata        = rec_reg;
        rec_raddr        = p_reg;
        el_we            = 1'b0;
        el_raddr         = {p_reg, rec_reg.chain[EAW-1:0]};
        el_waddr         = {p_reg, div_q[EAW-1:0]};
        el_wdata         = rec_reg.chain;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = opcode;
                    lh_next    = list_head;
                    lhv_next   = list_head_valid;
                    esz_next   = (elem_bytes < ESW'(4)) ? ESW'(4) : elem_bytes;
                    off_next   = free_offset;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                status_next   = 1'b0;
                offset_next   = '0;
                commit_next   = 1'b0;
                decommit_next = 1'b0;
                touched_next  = '0;
                echo_next     = 1'b0;
                head_next     = (lhv_reg && {1'b0, lh_reg} < cnt) ? {1'b0, lh_reg} : NIL_P;
                rec_raddr     = lh_reg;
                if (op_reg == OP_FREE)
                begin
                    div_start  = 1'b1;
                    state_next = S_F_DIVW1;
                end
                else if (lhv_reg && {1'b0, lh_reg} >= cnt)
                begin
                    status_next = 1'b1;
                    echo_next   = 1'b1;
                    state_next  = S_DONE;
                end
                else if (lhv_reg)
                begin
                    p_next     = lh_reg;
                    state_next = S_A_HEAD;
                end
                else if (esz_reg > ps)
                begin
                    status_next = 1'b1;
                    echo_next   = 1'b1;
                    state_next  = S_DONE;
                end
                else if (cache_head_reg != NIL_P)
                begin
                    // Reuse a committed page from the cache.
                    p_next          = cache_head_reg[PAW-1:0];
                    lreq.valid      = 1'b1;
                    lreq.cmd        = LC_OUT;
                    lreq.page       = cache_head_reg[PAW-1:0];
                    lreq.head       = cache_head_reg;
                    take_cache_next = 1'b1;
                    if (cache_count_reg != '0)
                    begin
                        cache_count_next = cache_count_reg - 1'b1;
                    end
                    state_next = S_A_TAKEW;
                end
                else if (virt_head_reg != NIL_P)
                begin
                    // Recommit a page from the virtual list.
                    p_next          = virt_head_reg[PAW-1:0];
                    lreq.valid      = 1'b1;
                    lreq.cmd        = LC_OUT;
                    lreq.page       = virt_head_reg[PAW-1:0];
                    lreq.head       = virt_head_reg;
                    take_cache_next = 1'b0;
                    commit_next     = 1'b1;
                    touched_next    = virt_head_reg[PAW-1:0];
                    state_next      = S_A_TAKEW;
                end
                else if (fresh_reg < cnt)
                begin
                    p_next       = fresh_reg[PAW-1:0];
                    fresh_next   = fresh_reg + 1'b1;
                    commit_next  = 1'b1;
                    touched_next = fresh_reg[PAW-1:0];
                    state_next   = S_A_DIV;
                end
                else
                begin
                    status_next = 1'b1;
                    echo_next   = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_A_TAKEW:
            begin
                if (lrsp.done)
                begin
                    if (take_cache_reg)
                    begin
                        cache_head_next = lrsp.head;
                    end
                    else
                    begin
                        virt_head_next = lrsp.head;
                    end
                    state_next = S_A_DIV;
                end
            end
            S_A_DIV:
            begin
                div_start  = 1'b1;
                div_a      = OFW'(ps);
                div_b      = esz_reg;
                state_next = S_A_DIVW;
            end
            S_A_DIVW:
            begin
                // Set up the new page and make it the only page of the list.
                if (div_done)
                begin
                    rec_next.chain = NIL_E;
                    rec_next.bump  = '0;
                    rec_next.used  = '0;
                    rec_next.total = (div_q > OFW'(MAX_ELEMS)) ? NIL_E : div_q[CW-1:0];
                    rec_next.esize = esz_reg;
                    lreq.valid     = 1'b1;
                    lreq.cmd       = LC_IN;
                    lreq.head      = NIL_P;
                    state_next     = S_A_LINKW;
                end
            end
            S_A_LINKW:
            begin
                if (lrsp.done)
                begin
                    head_next  = lrsp.head;
                    state_next = S_A_PICK;
                end
            end
            S_A_HEAD:
            begin
                rec_next = rec_rdata;
                if (!(rec_rdata.chain < rec_rdata.total) && !(rec_rdata.bump < rec_rdata.total))
                begin
                    status_next = 1'b1;
                    echo_next   = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_A_PICK;
                end
            end
            S_A_PICK:
            begin
                // Prefer the free chain, else the bump index.
                if (rec_reg.chain < rec_reg.total)
                begin
                    e_next     = rec_reg.chain;
                    state_next = S_A_CHAIN;
                end
                else
                begin
                    e_next        = rec_reg.bump;
                    rec_next.bump = rec_reg.bump + 1'b1;
                    state_next    = S_A_USE;
                end
            end
            S_A_CHAIN:
            begin
                rec_next.chain = el_rdata;
                state_next     = S_A_USE;
            end
            S_A_USE:
            begin
                rec_we         = 1'b1;
                rec_wdata      = rec_reg;
                rec_wdata.used = used_inc;
                rec_next.used  = used_inc;
                if (used_inc >= rec_reg.total)
                begin
                    lreq.valid = 1'b1;
                    lreq.cmd   = LC_OUT;
                    state_next = S_A_OUTW;
                end
                else
                begin
                    state_next = S_A_MUL1;
                end
            end
            S_A_OUTW:
            begin
                if (lrsp.done)
                begin
                    head_next  = lrsp.head;
                    state_next = S_A_MUL1;
                end
            end
            S_A_MUL1:
            begin
                offset_next = mul_p[OFW-1:0];
                state_next  = S_A_MUL2;
            end
            S_A_MUL2:
            begin
                mul_a       = e_reg;
                mul_b       = rec_reg.esize;
                offset_next = offset_reg + mul_p[OFW-1:0];
                state_next  = S_DONE;
            end
            S_F_DIVW1:
            begin
                rec_raddr = div_q[PAW-1:0];
                if (div_done)
                begin
                    rem_next = div_r;
                    if (div_q < OFW'(cnt))
                    begin
                        p_next     = div_q[PAW-1:0];
                        state_next = S_F_REC;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_F_REC:
            begin
                rec_next = rec_rdata;
                if (rec_rdata.esize != '0 && rec_rdata.used != '0)
                begin
                    div_start  = 1'b1;
                    div_a      = OFW'(rem_reg);
                    div_b      = rec_rdata.esize;
                    state_next = S_F_DIVW2;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_F_DIVW2:
            begin
                if (div_done)
                begin
                    if (div_q < OFW'(rec_reg.total))
                    begin
                        // Push the element onto the page's free chain.
                        e_next          = div_q[CW-1:0];
                        el_we           = 1'b1;
                        rec_we          = 1'b1;
                        rec_wdata       = rec_reg;
                        rec_wdata.chain = div_q[CW-1:0];
                        rec_wdata.used  = used_dec;
                        rec_next        = rec_wdata;
                        if (used_dec == '0)
                        begin
                            lreq.valid = 1'b1;
                            lreq.cmd   = LC_OUT_IF_LINKED;
                            state_next = S_F_OUTW;
                        end
                        else if (rec_reg.used >= rec_reg.total)
                        begin
                            lreq.valid = 1'b1;
                            lreq.cmd   = LC_IN;
                            state_next = S_F_INW;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_F_OUTW:
            begin
                // The emptied page goes to the cache or to the virtual list.
                if (lrsp.done)
                begin
                    head_next  = lrsp.head;
                    lreq.valid = 1'b1;
                    lreq.cmd   = LC_IN;
                    if (PNW'(cache_count_reg) < PNW'(cache_limit_reg) ||
                        cache_limit_reg > 9'(PAGES))
                    begin
                        lreq.head        = cache_head_reg;
                        take_cache_next  = 1'b1;
                        cache_count_next = cache_count_reg + 1'b1;
                    end
                    else
                    begin
                        lreq.head       = virt_head_reg;
                        take_cache_next = 1'b0;
                        decommit_next   = 1'b1;
                        touched_next    = p_reg;
                    end
                    state_next = S_F_PUTW;
                end
            end
            S_F_INW:
            begin
                if (lrsp.done)
                begin
                    head_next  = lrsp.head;
                    state_next = S_DONE;
                end
            end
            S_F_PUTW:
            begin
                if (lrsp.done)
                begin
                    if (take_cache_reg)
                    begin
                        cache_head_next = lrsp.head;
                    end
                    else
                    begin
                        virt_head_next = lrsp.head;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            fresh_reg       <= '0;
            cache_head_reg  <= NIL_P;
            cache_count_reg <= '0;
            virt_head_reg   <= NIL_P;
        end
        else
        begin
            state_reg       <= state_next;
            fresh_reg       <= fresh_next;
            cache_head_reg  <= cache_head_next;
            cache_count_reg <= cache_count_next;
            virt_head_reg   <= virt_head_next;
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        lh_reg         <= lh_next;
        lhv_reg        <= lhv_next;
        esz_reg        <= esz_next;
        off_reg        <= off_next;
        head_reg       <= head_next;
        p_reg          <= p_next;
        e_reg          <= e_next;
        rem_reg        <= rem_next;
        rec_reg        <= rec_next;
        take_cache_reg <= take_cache_next;
        status_reg     <= status_next;
        offset_reg     <= offset_next;
        commit_reg     <= commit_next;
        decommit_reg   <= decommit_next;
        touched_reg    <= touched_next;
        echo_reg       <= echo_next;
    end

    // Configuration register writes.
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_size_reg   <= 17'd4096;
            page_count_reg  <= 9'd256;
            cache_limit_reg <= 9'd4;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_PAGE_SIZE:   page_size_reg   <= pwdata[16:0];
                REG_PAGE_COUNT:  page_count_reg  <= pwdata[8:0];
                REG_CACHE_LIMIT: cache_limit_reg <= pwdata[8:0];
                default:         ;
            endcase
        end
    end

    // Configuration register reads.
    always_comb
    begin
        unique case (paddr[3:2])
            REG_PAGE_SIZE:   prdata = 32'(page_size_reg);
            REG_PAGE_COUNT:  prdata = 32'(page_count_reg);
            REG_CACHE_LIMIT: prdata = 32'(cache_limit_reg);
            default:         prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Result ports.
    assign busy           = (state_reg != S_IDLE);
    assign done           = (state_reg == S_DONE);
    assign status         = status_reg;
    assign alloc_offset   = offset_reg;
    assign commit_page    = commit_reg;
    assign decommit_page  = decommit_reg;
    assign touched_page   = 8'(touched_reg);
    assign new_head_valid = echo_reg ? lhv_reg : (head_reg != NIL_P);
    assign new_head       = echo_reg ? (lhv_reg ? lh_reg : 8'd0)
                                     : ((head_reg != NIL_P) ? 8'(head_reg) : 8'd0);

    // An accepted item keeps the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

    // A failed allocate touches no page and returns no offset.
    a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (!commit_page && !decommit_page && alloc_offset == '0))
        else $error("failed allocate reports a page action or offset");

    // A free never commits a page and never fails.
    a_free_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && op_reg == OP_FREE) |-> (!commit_page && !status))
        else $error("free reports commit or failure");

    // The cache never counts more pages than the range holds.
    a_cache_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cache_count_reg <= PNW'(PAGES))
        else $error("cache count exceeds page range");

endmodule

// ----- bench/tb_paged_slab_allocator_core.sv -----
// Self-checking testbench for the paged slab allocator core.
`timescale 1ns / 100ps

module tb_paged_slab_allocator_core;
    import psa_pkg::*;

    // Operation codes of the request opcode field.
    localparam bit OP_ALLOC = 1'b0;
    localparam bit OP_FREE  = 1'b1;

    // Configuration register indexes.
    localparam int REG_PAGE_SIZE   = 0;
    localparam int REG_PAGE_COUNT  = 1;
    localparam int REG_CACHE_LIMIT = 2;

    localparam int unsigned NILV  = PAGES;
    localparam int          LIMIT = 3000;

    typedef struct packed {
        bit        opcode;
        bit [7:0]  lh;
        bit        lhv;
        bit [16:0] eb;
        bit [23:0] off;
    } slab_req_t;

    typedef struct packed {
        logic        st;
        logic [23:0] aoff;
        logic [7:0]  nh;
        logic        nhv;
        logic        cm;
        logic        dc;
        logic [7:0]  tp;
    } slab_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        done;
    logic        opcode = 1'b0;
    logic [7:0]  list_head = '0;
    logic        list_head_valid = 1'b0;
    logic [16:0] elem_bytes = '0;
    logic [23:0] free_offset = '0;
    logic        status;
    logic [23:0] alloc_offset;
    logic [7:0]  new_head;
    logic        new_head_valid;
    logic        commit_page;
    logic        decommit_page;
    logic [7:0]  touched_page;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    paged_slab_allocator_core DUT (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Shadow copy of the allocator state.
    bit [PNW-1:0] pg_next [PAGES+1];
    bit [PNW-1:0] pg_prev [PAGES+1];
    bit           pg_phys [PAGES];
    bit [CW-1:0]  pg_chain [PAGES];
    bit [CW-1:0]  pg_bump [PAGES];
    bit [CW-1:0]  pg_used [PAGES];
    bit [CW-1:0]  pg_total [PAGES];
    bit [ESW-1:0] pg_esize [PAGES];
    bit [CW-1:0]  el_link [PAGES*MAX_ELEMS];
    bit           pg_init [PAGES];
    int unsigned  fresh_idx = 0;
    int unsigned  cache_hd = NILV;
    int unsigned  cache_cnt = 0;
    int unsigned  virt_hd = NILV;
    int unsigned  cfg_psize = 4096;
    int unsigned  cfg_pcount = 256;
    int unsigned  cfg_climit = 4;

    // Traffic bookkeeping.
    slab_req_t   pend_q[$];
    slab_res_t   expect_q[$];
    slab_res_t   last_res;
    slab_req_t   on_pins;
    int unsigned live_q[$];
    int          cls_head[int];
    int          n_pushed = 0;
    int          n_taken = 0;
    int          idle_pct = 0;
    int          mism = 0;
    int          quiet_cyc = 0;

    function automatic int unsigned eff_psize();
        return (cfg_psize == 0) ? 1 : cfg_psize;
    endfunction

    function automatic int unsigned eff_pcount();
        return (cfg_pcount < PAGES) ? cfg_pcount : PAGES;
    endfunction

    // Insert a page after the head of a circular list.
    function automatic void pg_attach(inout int unsigned hd, input int unsigned p);
        int unsigned n;
        if (hd >= NILV)
        begin
            pg_next[p] = p;
            pg_prev[p] = p;
            hd = p;
        end
        else
        begin
            n = pg_next[hd];
            pg_prev[p] = hd;
            pg_next[p] = n;
            pg_next[hd] = p;
            pg_prev[n] = p;
        end
    endfunction

    // Remove a page from its circular list, moving the head on if needed.
    function automatic void pg_detach(inout int unsigned hd, input int unsigned p);
        int unsigned pr;
        int unsigned nx;
        pr = pg_prev[p];
        nx = pg_next[p];
        pg_next[pr] = nx;
        pg_prev[nx] = pr;
        pg_next[p] = NILV;
        pg_prev[p] = NILV;
        if (hd == p)
            hd = (nx == p) ? NILV : nx;
    endfunction

    // Work out the result of one request and advance the shadow state.
    function automatic slab_res_t slab_predict(input slab_req_t rq);
        slab_res_t   rs;
        int unsigned ps;
        int unsigned cnt;
        int unsigned hd;
        int unsigned p;
        int unsigned e;
        int unsigned esz;
        int unsigned tot;
        bit          ok;
        bit          echo;
        bit          was_full;
        longint unsigned offs;
        rs = '0;
        ps = eff_psize();
        cnt = eff_pcount();
        hd = (rq.lhv && rq.lh < cnt) ? rq.lh : NILV;
        echo = 1'b0;
        offs = 0;
        p = 0;
        if (rq.opcode == OP_ALLOC)
        begin
            if (rq.lhv && rq.lh >= cnt)
            begin
                rs.st = 1'b1;
                echo = 1'b1;
            end
            else
            begin
                ok = 1'b1;
                if (hd == NILV)
                begin
                    // Empty list: open a page from cache, virtual list or fresh page index.
                    esz = (rq.eb < 4) ? 4 : rq.eb;
                    if (esz > ps)
                        ok = 1'b0;
                    else if (cache_hd < NILV)
                    begin
                        p = cache_hd;
                        pg_detach(cache_hd, p);
                        if (cache_cnt != 0)
                            cache_cnt--;
                    end
                    else if (virt_hd < NILV)
                    begin
                        p = virt_hd;
                        pg_detach(virt_hd, p);
                        rs.cm = 1'b1;
                        rs.tp = p[7:0];
                    end
                    else if (fresh_idx < cnt)
                    begin
                        p = fresh_idx;
                        fresh_idx++;
                        rs.cm = 1'b1;
                        rs.tp = p[7:0];
                    end
                    else
                        ok = 1'b0;
                    if (ok)
                    begin
                        tot = ps / esz;
                        if (tot > MAX_ELEMS)
                            tot = MAX_ELEMS;
                        pg_next[p] = NILV;
                        pg_prev[p] = NILV;
                        pg_phys[p] = 1'b1;
                        pg_chain[p] = NIL_E;
                        pg_bump[p] = '0;
                        pg_used[p] = '0;
                        pg_total[p] = tot;
                        pg_esize[p] = esz;
                        pg_init[p] = 1'b1;
                        pg_attach(hd, p);
                    end
                end
                else
                begin
                    p = hd;
                    if (!(pg_chain[p] < pg_total[p]) && !(pg_bump[p] < pg_total[p]))
                        ok = 1'b0;
                end
                if (ok)
                begin
                    // Hand out a chained element first, else the next bump element.
                    if (pg_chain[p] < pg_total[p])
                    begin
                        e = pg_chain[p];
                        pg_chain[p] = el_link[p*MAX_ELEMS + e];
                    end
                    else
                    begin
                        e = pg_bump[p];
                        pg_bump[p] = pg_bump[p] + 1;
                    end
                    pg_used[p] = pg_used[p] + 1;
                    if (pg_used[p] >= pg_total[p])
                        pg_detach(hd, p);
                    offs = longint'(p) * ps + longint'(e) * pg_esize[p];
                end
                else
                begin
                    rs.st = 1'b1;
                    rs.cm = 1'b0;
                    rs.tp = '0;
                    echo = 1'b1;
                end
            end
        end
        else
        begin
            p = rq.off / ps;
            if (p < cnt && pg_esize[p] != 0 && pg_used[p] != 0)
            begin
                e = (rq.off - p * ps) / pg_esize[p];
                if (e < pg_total[p])
                begin
                    was_full = pg_used[p] >= pg_total[p];
                    el_link[p*MAX_ELEMS + e] = pg_chain[p];
                    pg_chain[p] = e;
                    pg_used[p] = pg_used[p] - 1;
                    if (pg_used[p] == 0)
                    begin
                        // An emptied page is cached, or decommitted once the cache is full.
                        if (pg_next[p] != NILV)
                            pg_detach(hd, p);
                        if (cache_cnt < cfg_climit)
                        begin
                            pg_attach(cache_hd, p);
                            cache_cnt++;
                        end
                        else
                        begin
                            pg_phys[p] = 1'b0;
                            pg_attach(virt_hd, p);
                            rs.dc = 1'b1;
                            rs.tp = p[7:0];
                        end
                    end
                    else if (was_full)
                        pg_attach(hd, p);
                end
            end
        end
        rs.aoff = offs[23:0];
        if (echo)
        begin
            rs.nh = rq.lhv ? rq.lh : 8'd0;
            rs.nhv = rq.lhv;
        end
        else
        begin
            rs.nh = (hd < NILV) ? hd[7:0] : 8'd0;
            rs.nhv = hd < NILV;
        end
        return rs;
    endfunction

    // Request driver: predicts each item as it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        bit go;
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            go = start;
            if (start && !busy)
            begin
                last_res = slab_predict(on_pins);
                expect_q.push_back(last_res);
                n_taken++;
                go = 1'b0;
            end
            if (!go && pend_q.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                on_pins = pend_q.pop_front();
                go = 1'b1;
                opcode <= on_pins.opcode;
                list_head <= on_pins.lh;
                list_head_valid <= on_pins.lhv;
                elem_bytes <= on_pins.eb;
                free_offset <= on_pins.off;
            end
            start <= go;
        end
    end

    task automatic report(input string what, input slab_res_t ex, input slab_res_t got);
        mism++;
        if (mism <= 10)
            $display("%0t %s: expected st=%0d off=%h head=%0d/%0d cm=%0d dc=%0d pg=%0d, got st=%0d off=%h head=%0d/%0d cm=%0d dc=%0d pg=%0d",
                     $time, what, ex.st, ex.aoff, ex.nhv, ex.nh, ex.cm, ex.dc, ex.tp,
                     got.st, got.aoff, got.nhv, got.nh, got.cm, got.dc, got.tp);
    endtask

    // Result monitor.
    always @(posedge clk)
    begin
        slab_res_t got;
        slab_res_t ex;
        if (rst_n && done)
        begin
            got = '{status, alloc_offset, new_head, new_head_valid,
                    commit_page, decommit_page, touched_page};
            if (expect_q.size() == 0)
                report("unexpected result", '0, got);
            else
            begin
                ex = expect_q.pop_front();
                if (got !== ex)
                    report("result mismatch", ex, got);
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cyc <= 0;
            else
                quiet_cyc <= quiet_cyc + 1;
            if (quiet_cyc >= LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic cfg_write(input int idx, input int unsigned val);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 4'(4 * idx);
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_PAGE_SIZE:   cfg_psize = val & 32'h1FFFF;
            REG_PAGE_COUNT:  cfg_pcount = val & 32'h1FF;
            REG_CACHE_LIMIT: cfg_climit = val & 32'h1FF;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (expect_q.size() != 0 || n_taken != n_pushed)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic int head_of(input int key);
        return cls_head.exists(key) ? cls_head[key] : -1;
    endfunction

    // A free is only sent where it touches no page that was never opened.
    function automatic bit free_safe(input int unsigned off);
        int unsigned p;
        int          h;
        p = off / eff_psize();
        if (p >= eff_pcount())
            return 1'b1;
        if (!pg_init[p])
            return 1'b0;
        h = head_of(pg_esize[p]);
        return h < 0 || h < eff_pcount();
    endfunction

    // Send one item, wait for it to be taken and track the caller's lists.
    task automatic issue(input slab_req_t it, input int key);
        int i;
        if (it.opcode == OP_FREE)
            for (i = 0; i < live_q.size(); i++)
                if (live_q[i] == it.off)
                begin
                    live_q.delete(i);
                    break;
                end
        pend_q.push_back(it);
        n_pushed++;
        while (n_taken != n_pushed)
            @(negedge clk);
        if (key >= 0)
            cls_head[key] = last_res.nhv ? int'(last_res.nh) : -1;
        if (it.opcode == OP_ALLOC && !last_res.st)
            live_q.push_back(last_res.aoff);
    endtask

    task automatic send_alloc(input int unsigned eb);
        slab_req_t it;
        int        key;
        int        h;
        key = (eb < 4) ? 4 : eb;
        h = head_of(key);
        it.opcode = OP_ALLOC;
        it.lhv = h >= 0;
        it.lh = (h >= 0) ? h[7:0] : 8'($urandom);
        it.eb = eb;
        it.off = 24'($urandom);
        issue(it, key);
    endtask

    task automatic send_free(input int unsigned off);
        slab_req_t   it;
        int unsigned p;
        int          key;
        int          h;
        p = off / eff_psize();
        key = (p < eff_pcount() && pg_init[p]) ? int'(pg_esize[p]) : -1;
        h = (key >= 0) ? head_of(key) : -1;
        it.opcode = OP_FREE;
        it.lhv = (h >= 0) ? 1'b1 : (key < 0 && $urandom_range(1) == 1);
        it.lh = (h >= 0) ? h[7:0] : 8'($urandom);
        it.eb = 17'($urandom);
        it.off = off;
        issue(it, key);
    endtask

    function automatic int unsigned pick_size();
        int unsigned ps;
        ps = eff_psize();
        case ($urandom_range(9))
            0: return $urandom_range(3);
            1: return 4;
            2: return 8;
            3: return 24;
            4: return 100;
            5: return (ps / 3 > 65536) ? 65536 : ps / 3;
            6: return ps / 2;
            7: return ps;
            8: return $urandom_range(65536, 4);
            default: return $urandom_range(131071, 65537);
        endcase
    endfunction

    // One random item: mostly well-formed allocate and free traffic.
    task automatic rand_item();
        int unsigned r;
        int unsigned off;
        int unsigned cnt;
        int          p;
        int          i;
        slab_req_t   it;
        r = $urandom_range(99);
        cnt = eff_pcount();
        if ($urandom_range(49) == 0)
            while (expect_q.size() != 0)
                @(negedge clk);
        if (r < 50)
            send_alloc(pick_size());
        else if (r < 85 && live_q.size() > 0)
        begin
            off = live_q[$urandom_range(live_q.size() - 1)];
            if (free_safe(off))
                send_free(off);
            else
                send_alloc(pick_size());
        end
        else if (r < 94)
        begin
            if ($urandom_range(1))
                off = 24'($urandom);
            else
                off = $urandom_range(eff_psize() * cnt - 1) & 24'hFFFFFF;
            if (free_safe(off))
                send_free(off);
            else
                send_alloc(pick_size());
        end
        else
        begin
            // Allocate with a head out of range, or naming a page already full.
            p = -1;
            if (cnt < PAGES)
                p = $urandom_range(255, cnt);
            else
                for (i = 0; i < fresh_idx; i++)
                    if (pg_init[i] && !(pg_chain[i] < pg_total[i])
                        && !(pg_bump[i] < pg_total[i]))
                    begin
                        p = i;
                        break;
                    end
            if (p < 0)
                send_alloc(pick_size());
            else
            begin
                it.opcode = OP_ALLOC;
                it.lhv = 1'b1;
                it.lh = p[7:0];
                it.eb = 17'($urandom);
                it.off = 24'($urandom);
                issue(it, -1);
            end
        end
    endtask

    task automatic run_phase(input int unsigned ps, input int unsigned cnt,
                             input int unsigned cl, input int idle, input int n);
        drain();
        cfg_write(REG_PAGE_SIZE, ps);
        cfg_write(REG_PAGE_COUNT, cnt);
        cfg_write(REG_CACHE_LIMIT, cl);
        @(negedge clk);
        idle_pct = idle;
        repeat (n) rand_item();
    endtask

    initial
    begin
        slab_req_t it;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed items at the reset configuration.
        send_alloc(2048);
        send_alloc(2048);
        it = '{OP_ALLOC, 8'd0, 1'b1, 17'd2048, 24'hFFFFFF};
        issue(it, -1);
        send_free(2048);
        send_free(0);
        send_alloc(1);
        send_alloc(65536);
        send_alloc(131071);
        send_free(24'hFFFFFF);
        send_alloc(3000);
        send_free(4096 + 3000);
        send_free(4096);
        send_free(4096);
        send_alloc(4);
        send_alloc(4);
        send_free(4);
        send_free(0);
        send_alloc(4096);
        send_free(8192);

        run_phase(64, 256, 0, 60, 300);
        run_phase(65536, 3, 256, 37, 300);
        run_phase(0, 256, 4, 0, 100);
        run_phase(4096, 256, 2, 60, 400);
        run_phase(1000, 1, 1, 37, 150);
        run_phase(512, 200, 8, 0, 500);

        drain();
        repeat (100) @(posedge clk);
        if (mism == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/psa_pkg.sv
rtl/core/psa_ram.sv
rtl/core/psa_div.sv
rtl/core/psa_list.sv
rtl/core/paged_slab_allocator_core.sv
bench/tb_paged_slab_allocator_core.sv
